// ----- hw/rtl/simt_pkg.sv -----
// ----------------------------------------------------------------------------
// simt_pkg
// Shared types, constants and helpers for the shadow interval merge table.
// ----------------------------------------------------------------------------
package simt_pkg;

   localparam int unsigned SLOPE_FRAC_BITS   = 16;
   localparam int unsigned SLOPE_W           = SLOPE_FRAC_BITS + 1;
   localparam int unsigned COUNT_W           = 6;
   localparam int unsigned MAX_INTERVALS_DEF = 32;

   typedef logic [SLOPE_W-1:0] slope_type;

   localparam slope_type SLOPE_ONE = slope_type'(1) << SLOPE_FRAC_BITS;

   typedef struct packed {
      slope_type lo;
      slope_type hi;
   } entry_type;

   typedef struct packed {
      logic      new_scan;
      slope_type slope_start;
      slope_type slope_end;
      logic      blocks_sight;
   } req_type;

   typedef struct packed {
      logic               visible;
      logic               full_shadow;
      logic               table_overflow;
      logic [COUNT_W-1:0] interval_count;
   } rsp_type;

   // Kind of list update chosen after the scan.
   typedef enum logic [2:0] {
      OP_NONE,
      OP_BOTH,
      OP_NEXT,
      OP_PREV,
      OP_INSERT,
      OP_OVF
   } op_type;

   typedef struct packed {
      logic start;
      logic scan;
      logic decide;
      logic shl;
      logic shr;
      logic put;
      logic head;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic   scan_done;
      logic   shl_done;
      logic   shr_done;
      op_type op;
   } sts_type;

   // Slopes above 1.0 saturate to 1.0.
   function automatic slope_type clamp_slope(slope_type v);
      return (v > SLOPE_ONE) ? SLOPE_ONE : v;
   endfunction

endpackage

// ----- hw/rtl/simt_dpath.sv -----
// ----------------------------------------------------------------------------
// simt_dpath
// Interval memory, scan registers, shift engine and response register.
// ----------------------------------------------------------------------------
module simt_dpath #(
   parameter int unsigned MAX_INTERVALS = simt_pkg::MAX_INTERVALS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  simt_pkg::req_type req_data,
   input  simt_pkg::cmd_type cmd,
   output simt_pkg::sts_type sts,
   output simt_pkg::rsp_type rsp_data
);
   import simt_pkg::*;

   localparam int unsigned CW = $clog2(MAX_INTERVALS + 1);
   localparam int unsigned AW = $clog2(MAX_INTERVALS);

   entry_type mem [MAX_INTERVALS];

   slope_type lo_ff, lo_in;
   slope_type hi_ff, hi_in;
   logic      blk_ff, blk_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [CW-1:0] pos_ff, pos_in;
   logic [CW-1:0] rd_idx_ff, rd_idx_in;
   logic      rd_vld_ff;
   logic      covered_ff, covered_in;
   logic      found_ff, found_in;
   logic      ovf_ff, ovf_in;
   entry_type last_ff, last_in;
   entry_type next_ff, next_in;
   entry_type rd_data_ff;
   rsp_type   rsp_ff, rsp_in;

   logic          rd_en;
   logic [CW-1:0] rd_addr;
   logic          wr_en;
   logic [CW-1:0] wr_addr;
   entry_type     wr_data;

   logic act;
   logic prev_hit;
   logic next_hit;

   // Update decision from the scan results.
   always_comb begin
      act      = !covered_ff && blk_ff;
      prev_hit = (pos_ff != '0) && (last_ff.hi > lo_ff);
      next_hit = found_ff && (next_ff.lo < hi_ff);
      sts.scan_done = !(idx_ff < cnt_ff) && !rd_vld_ff;
      sts.shl_done  = !(idx_ff <= cnt_ff) && !rd_vld_ff;
      sts.shr_done  = !(idx_ff > pos_ff) && !rd_vld_ff;
      priority if (!act) begin
         sts.op = OP_NONE;
      end else if (prev_hit && next_hit) begin
         sts.op = OP_BOTH;
      end else if (next_hit) begin
         sts.op = OP_NEXT;
      end else if (prev_hit) begin
         sts.op = OP_PREV;
      end else if (cnt_ff >= CW'(MAX_INTERVALS)) begin
         sts.op = OP_OVF;
      end else begin
         sts.op = OP_INSERT;
      end
   end

   // Memory port selection.
   always_comb begin
      rd_en   = 1'b0;
      rd_addr = idx_ff;
      wr_en   = 1'b0;
      wr_addr = pos_ff;
      wr_data = '{lo: lo_ff, hi: hi_ff};
      if (cmd.scan && (idx_ff < cnt_ff)) begin
         rd_en = 1'b1;
      end
      if (cmd.shl && (idx_ff <= cnt_ff)) begin
         rd_en = 1'b1;
      end
      if (cmd.shr && (idx_ff > pos_ff)) begin
         rd_en   = 1'b1;
         rd_addr = idx_ff - CW'(1);
      end
      if (cmd.head) begin
         rd_en   = 1'b1;
         rd_addr = '0;
      end
      if (cmd.decide) begin
         unique case (sts.op)
            OP_BOTH: begin
               wr_en   = 1'b1;
               wr_addr = pos_ff - CW'(1);
               wr_data = '{lo: last_ff.lo, hi: next_ff.hi};
            end
            OP_NEXT: begin
               wr_en   = 1'b1;
               wr_data = '{lo: lo_ff, hi: next_ff.hi};
            end
            OP_PREV: begin
               wr_en   = 1'b1;
               wr_addr = pos_ff - CW'(1);
               wr_data = '{lo: last_ff.lo, hi: hi_ff};
            end
            default: begin
               wr_en = 1'b0;
            end
         endcase
      end
      if (cmd.shl && rd_vld_ff) begin
         wr_en   = 1'b1;
         wr_addr = rd_idx_ff - CW'(1);
         wr_data = rd_data_ff;
      end
      if (cmd.shr && rd_vld_ff) begin
         wr_en   = 1'b1;
         wr_addr = rd_idx_ff + CW'(1);
         wr_data = rd_data_ff;
      end
      if (cmd.put) begin
         wr_en = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr[AW-1:0]] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr[AW-1:0]];
      end
   end

   // Register updates.
   always_comb begin
      lo_in      = lo_ff;
      hi_in      = hi_ff;
      blk_in     = blk_ff;
      cnt_in     = cnt_ff;
      idx_in     = idx_ff;
      pos_in     = pos_ff;
      rd_idx_in  = rd_addr;
      covered_in = covered_ff;
      found_in   = found_ff;
      ovf_in     = ovf_ff;
      last_in    = last_ff;
      next_in    = next_ff;
      rsp_in     = rsp_ff;
      if (cmd.start) begin
         lo_in      = clamp_slope(req_data.slope_start);
         hi_in      = clamp_slope(req_data.slope_end);
         blk_in     = req_data.blocks_sight;
         cnt_in     = req_data.new_scan ? '0 : cnt_ff;
         pos_in     = req_data.new_scan ? '0 : cnt_ff;
         idx_in     = '0;
         covered_in = 1'b0;
         found_in   = 1'b0;
         ovf_in     = 1'b0;
      end
      if (cmd.scan) begin
         if (rd_en) begin
            idx_in = idx_ff + CW'(1);
         end
         if (rd_vld_ff) begin
            if ((rd_data_ff.lo <= lo_ff) && (rd_data_ff.hi >= hi_ff)) begin
               covered_in = 1'b1;
            end
            if (!found_ff) begin
               if (rd_data_ff.lo >= lo_ff) begin
                  found_in = 1'b1;
                  pos_in   = rd_idx_ff;
                  next_in  = rd_data_ff;
               end else begin
                  last_in = rd_data_ff;
               end
            end
         end
      end
      if (cmd.decide) begin
         unique case (sts.op)
            OP_BOTH: begin
               cnt_in = cnt_ff - CW'(1);
               idx_in = pos_ff + CW'(1);
            end
            OP_INSERT: begin
               idx_in = cnt_ff;
            end
            OP_OVF: begin
               ovf_in = 1'b1;
            end
            default: begin
               ovf_in = ovf_ff;
            end
         endcase
      end
      if (cmd.shl && rd_en) begin
         idx_in = idx_ff + CW'(1);
      end
      if (cmd.shr && rd_en) begin
         idx_in = idx_ff - CW'(1);
      end
      if (cmd.put) begin
         cnt_in = cnt_ff + CW'(1);
      end
      if (cmd.load_rsp) begin
         rsp_in.visible        = !covered_ff;
         rsp_in.full_shadow    = (cnt_ff != '0) && (rd_data_ff.lo == '0) &&
                                 (rd_data_ff.hi == SLOPE_ONE);
         rsp_in.table_overflow = ovf_ff;
         rsp_in.interval_count = COUNT_W'(cnt_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         cnt_ff    <= cnt_in;
         rd_vld_ff <= rd_en;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      blk_ff     <= blk_in;
      idx_ff     <= idx_in;
      pos_ff     <= pos_in;
      rd_idx_ff  <= rd_idx_in;
      covered_ff <= covered_in;
      found_ff   <= found_in;
      ovf_ff     <= ovf_in;
      last_ff    <= last_in;
      next_ff    <= next_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_data = rsp_ff;

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(MAX_INTERVALS))
      else $error("interval count exceeds table depth");

   a_put_grows: assert property (@(posedge clock) disable iff (reset)
      cmd.put |=> (cnt_ff == $past(cnt_ff) + CW'(1)))
      else $error("insert did not grow the list by one");

   a_shr_inside: assert property (@(posedge clock) disable iff (reset)
      (cmd.shr && rd_vld_ff) |-> (rd_idx_ff < cnt_ff))
      else $error("right shift moved an entry from beyond the list");

endmodule

// ----- hw/rtl/simt_ctrl.sv -----
// ----------------------------------------------------------------------------
// simt_ctrl
// Sequencer for scan, update, shift and response phases of one transaction.
// ----------------------------------------------------------------------------
module simt_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  simt_pkg::sts_type sts,
   output simt_pkg::cmd_type cmd
);
   import simt_pkg::*;

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_SCAN   = 8'b0000_0010,
      ST_DECIDE = 8'b0000_0100,
      ST_SHL    = 8'b0000_1000,
      ST_SHR    = 8'b0001_0000,
      ST_PUT    = 8'b0010_0000,
      ST_HEAD   = 8'b0100_0000,
      ST_FIN    = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      slot_free    = !rsp_valid_ff || rsp_ready;
      cmd          = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.scan_done) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            cmd.decide = 1'b1;
            unique case (sts.op)
               OP_BOTH:   state_in = ST_SHL;
               OP_INSERT: state_in = ST_SHR;
               default:   state_in = ST_HEAD;
            endcase
         end
         ST_SHL: begin
            cmd.shl = 1'b1;
            if (sts.shl_done) begin
               state_in = ST_HEAD;
            end
         end
         ST_SHR: begin
            cmd.shr = 1'b1;
            if (sts.shr_done) begin
               state_in = ST_PUT;
            end
         end
         ST_PUT: begin
            cmd.put  = 1'b1;
            state_in = ST_HEAD;
         end
         ST_HEAD: begin
            cmd.head = 1'b1;
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (slot_free) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- hw/rtl/shadow_interval_merge_table_top.sv -----
// ----------------------------------------------------------------------------
// shadow_interval_merge_table_top
// Sorted shadow interval list for one octant of a shadowcasting scan.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake              Payload
//   req_     in         req_valid / req_ready  simt_pkg::req_type (tile projection)
//   rsp_     out        rsp_valid / rsp_ready  simt_pkg::rsp_type (visibility, count)
//
// A transaction holds the sequencer for a scan at one entry per cycle
// through the single read port of the interval memory, an update, a head
// read and the response step. An insert or a join also moves the entries
// behind the tile, which adds a shift step before the head read.
// Reset empties the list at once; the memory itself is not cleared.
// A new transaction is taken while an earlier response still waits, and the
// sequencer holds in its final step while the response register is occupied.
//
// Each request reports whether the projection is visible (no stored interval
// contains it). A visible, sight-blocking tile is merged into the list: it
// extends the neighbor before it, the neighbor after it, joins the two, or is
// inserted in order. When an insert is needed but the list is full, the
// projection is dropped and table_overflow is raised. A set new_scan flag
// empties the list before the tile is handled. Input slopes above 1.0
// saturate to 1.0.
// ----------------------------------------------------------------------------
module shadow_interval_merge_table_top #(
   parameter int unsigned MAX_INTERVALS = simt_pkg::MAX_INTERVALS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  simt_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output simt_pkg::rsp_type rsp_data
);
   import simt_pkg::*;

   // Command and status between the sequencer and the datapath.
   cmd_type cmd;
   sts_type sts;

   // The sequencer owns the handshakes and the response valid flag.
   simt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // The datapath holds the interval memory and the response register.
   simt_dpath #(
      .MAX_INTERVALS (MAX_INTERVALS)
   ) u_dpath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .sts      (sts),
      .rsp_data (rsp_data)
   );

endmodule
